// File: rtl/core/rrt_pkg.sv
// Shared types and constants for the request reassembly table.
`default_nettype none
package rrt_pkg;

    localparam int CLIENT_BITS  = 16;
    localparam int REQUEST_BITS = 32;
    localparam int SLOT_BITS    = 3;
    localparam int TOTAL_BITS   = 4;
    localparam int TYPE_BITS    = 16;
    localparam int OUT_HANDLE_BITS = 16;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // Outcome of the lookup of one beat
    typedef enum logic [1:0] {
        LK_HIT_WAIT = 2'd0,
        LK_COMPLETE = 2'd1,
        LK_SINGLE   = 2'd2,
        LK_DROP     = 2'd3
    } lookup_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch input beat
        logic update;      // apply lookup to the table
        logic emit_load;   // load output register with current slot or beat
        logic slot_clr;    // restart slot walk
        logic slot_inc;    // advance slot walk
    } rrt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        lookup_kind_t kind;
        logic         walk_last;
    } rrt_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/rrt_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module rrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/rrt_datapath.sv
// Entry table, match logic, handle memory and output register.
`default_nettype none
module rrt_datapath
    import rrt_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int MAX_PACKETS = 8,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rrt_cmd_t                cmd,
    output rrt_sts_t                     sts,
    input  wire logic [CLIENT_BITS-1:0]  src_client,
    input  wire logic [REQUEST_BITS-1:0] request_id,
    input  wire logic [SLOT_BITS-1:0]    slot_number,
    input  wire logic [TOTAL_BITS-1:0]   total_packets,
    input  wire logic [TYPE_BITS-1:0]    request_type,
    input  wire logic [15:0]             buffer_handle,
    output logic                         status,
    output logic [CLIENT_BITS-1:0]       out_client,
    output logic [REQUEST_BITS-1:0]      out_request_id,
    output logic [TYPE_BITS-1:0]         out_type,
    output logic [SLOT_BITS-1:0]         out_slot,
    output logic [OUT_HANDLE_BITS-1:0]   out_handle,
    output logic                         last
);
    localparam int EB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PB = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int CB = $clog2(MAX_PACKETS + 1);
    localparam int HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int DEPTH = ENTRIES * (1 << PB);

    // Entry table
    logic [ENTRIES-1:0]    valid_reg;
    logic [CLIENT_BITS-1:0]  ent_client  [ENTRIES];
    logic [REQUEST_BITS-1:0] ent_request [ENTRIES];
    logic [TYPE_BITS-1:0]    ent_type    [ENTRIES];
    logic [CB-1:0]           ent_total   [ENTRIES];
    logic [CB-1:0]           ent_remain  [ENTRIES];
    logic [MAX_PACKETS-1:0]  ent_filled  [ENTRIES];

    // Captured beat
    logic [CLIENT_BITS-1:0]  cl_reg;
    logic [REQUEST_BITS-1:0] rq_reg;
    logic [SLOT_BITS-1:0]    sl_reg;
    logic [CB-1:0]           tot_reg;
    logic [TYPE_BITS-1:0]    ty_reg;
    logic [HB-1:0]           h_reg;

    // Walk and completed-entry info
    logic [EB-1:0] done_e_reg;
    logic [CB-1:0] walk_reg;
    logic [CB-1:0] done_tot_reg;
    logic          walk_valid_reg;

    // Total clamp
    logic [CB-1:0] tot_in;
    always_comb
    begin
        if (total_packets == '0)
            tot_in = CB'(1);
        else if (32'(total_packets) > MAX_PACKETS)
            tot_in = CB'(MAX_PACKETS);
        else
            tot_in = CB'(total_packets);
    end

    // Associative match and free search
    logic          hit;
    logic [EB-1:0] hit_e;
    logic          fre;
    logic [EB-1:0] fre_e;
    always_comb
    begin
        hit = 1'b0;
        hit_e = '0;
        fre = 1'b0;
        fre_e = '0;
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (valid_reg[e])
            begin
                if (ent_client[e] == cl_reg && ent_request[e] == rq_reg)
                begin
                    hit = 1'b1;
                    hit_e = EB'(e);
                end
            end
            else
            begin
                fre = 1'b1;
                fre_e = EB'(e);
            end
        end
    end

    logic [CB-1:0] rem_dec;
    logic          slot_ok_hit;
    logic          slot_ok_new;
    always_comb
    begin
        rem_dec = (ent_remain[hit_e] != '0) ? ent_remain[hit_e] - CB'(1) : '0;
        slot_ok_hit = 32'(sl_reg) < 32'(ent_total[hit_e]);
        slot_ok_new = 32'(sl_reg) < 32'(tot_reg);
        if (hit)
            sts.kind = (rem_dec == '0) ? LK_COMPLETE : LK_HIT_WAIT;
        else if (tot_reg == CB'(1))
            sts.kind = LK_SINGLE;
        else if (!fre)
            sts.kind = LK_DROP;
        else
            sts.kind = LK_HIT_WAIT;
        sts.walk_last = (walk_reg == done_tot_reg);
    end

    // Handle memory write port and read address
    logic          ram_we;
    logic [$clog2(DEPTH)-1:0] ram_waddr;
    logic [$clog2(DEPTH)-1:0] ram_raddr;
    logic [HB-1:0] ram_rdata;
    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = {hit ? hit_e : fre_e, sl_reg[PB-1:0]};
        if (cmd.update)
        begin
            if (hit)
                ram_we = slot_ok_hit;
            else if (tot_reg != CB'(1) && fre)
                ram_we = slot_ok_new;
        end
        ram_raddr = {done_e_reg, walk_reg[PB-1:0]};
    end

    rrt_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_handles (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (h_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Valid bits and walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            walk_reg <= '0;
            walk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                if (hit && rem_dec == '0)
                    valid_reg[hit_e] <= 1'b0;
                else if (!hit && tot_reg != CB'(1) && fre)
                    valid_reg[fre_e] <= 1'b1;
            end
            if (cmd.slot_clr)
                walk_reg <= '0;
            else if (cmd.slot_inc)
                walk_reg <= walk_reg + CB'(1);
            // walk flag lives from the completing lookup to the next capture
            if (cmd.slot_clr)
                walk_valid_reg <= 1'b1;
            else if (cmd.capture)
                walk_valid_reg <= 1'b0;
        end
    end

    // Entry payload and capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cl_reg <= src_client;
            rq_reg <= request_id;
            sl_reg <= slot_number;
            tot_reg <= tot_in;
            ty_reg <= request_type;
            h_reg <= buffer_handle[HB-1:0];
        end
        if (cmd.update)
        begin
            if (hit)
            begin
                ent_remain[hit_e] <= rem_dec;
                if (slot_ok_hit)
                    ent_filled[hit_e][sl_reg[PB-1:0]] <= 1'b1;
                done_e_reg <= hit_e;
                done_tot_reg <= ent_total[hit_e] - CB'(1);
            end
            else if (tot_reg != CB'(1) && fre)
            begin
                ent_client[fre_e] <= cl_reg;
                ent_request[fre_e] <= rq_reg;
                ent_type[fre_e] <= ty_reg;
                ent_total[fre_e] <= tot_reg;
                ent_remain[fre_e] <= tot_reg - CB'(1);
                ent_filled[fre_e] <= slot_ok_new
                    ? (MAX_PACKETS'(1) << sl_reg[PB-1:0]) : '0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            if (walk_valid_reg)
            begin
                status <= STATUS_DONE;
                out_client <= ent_client[done_e_reg];
                out_request_id <= ent_request[done_e_reg];
                out_type <= ent_type[done_e_reg];
                out_slot <= SLOT_BITS'(walk_reg);
                out_handle <= ent_filled[done_e_reg][walk_reg[PB-1:0]]
                    ? OUT_HANDLE_BITS'(ram_rdata) : '0;
                last <= (walk_reg == done_tot_reg);
            end
            else
            begin
                status <= (sts.kind == LK_DROP) ? STATUS_DROP : STATUS_DONE;
                out_client <= cl_reg;
                out_request_id <= rq_reg;
                out_type <= ty_reg;
                out_slot <= (sts.kind == LK_DROP) ? sl_reg : '0;
                out_handle <= (sts.kind == LK_DROP || sl_reg == '0)
                    ? OUT_HANDLE_BITS'(h_reg) : '0;
                last <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/rrt_ctrl.sv
// Sequencing state machine: capture, lookup, result walk.
`default_nettype none
module rrt_ctrl
    import rrt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output rrt_cmd_t      cmd,
    input  wire rrt_sts_t sts
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_EMIT,
        S_HOLD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   walk_end_reg;

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:   cmd.capture = in_valid;
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    cmd.update = 1'b1;
                    case (sts.kind)
                        LK_COMPLETE: cmd.slot_clr = 1'b1;
                        LK_SINGLE,
                        LK_DROP:     cmd.emit_load = 1'b1;
                        default:     ;
                    endcase
                end
            end
            S_READ:   ;
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.slot_inc = !walk_end_reg;
                end
            end
            S_HOLD:   cmd.slot_inc = 1'b0;
            default:  ;
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            walk_end_reg <= 1'b0;
        end
        else
        begin
            if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.emit_load)
                out_valid_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_LOOKUP;
                S_LOOKUP:
                    if (out_free)
                    begin
                        if (sts.kind == LK_COMPLETE)
                            state_reg <= S_READ;
                        else
                            state_reg <= S_IDLE;
                    end
                S_READ:
                begin
                    walk_end_reg <= sts.walk_last;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                    if (out_free)
                        state_reg <= walk_end_reg ? S_IDLE : S_READ;
                S_HOLD:   state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/request_reassembly_table.sv
// Request reassembly table: matches packets to open requests, emits completed ones.
// Usage:
//   Input channel (in_valid/in_stall) takes one packet beat: client, request id,
//   slot, total, type and buffer handle. The table is searched in parallel on
//   client and request id; a miss opens the lowest free entry.
//   Output channel (out_valid/out_stall) delivers result beats. A packet that
//   completes its request produces one beat per slot 0..total-1, in slot order,
//   last set on the final one. A one-packet request completes at once; a packet
//   that finds no free entry gives one drop beat (status 1).
// Sequencing:
//   A packet that produces no result passes through capture and lookup/update.
//   A single or drop beat is loaded into the output register at lookup. A completion
//   reads each slot from the handle RAM, with a read state and an emit state per result
//   beat, since the read port of that RAM is registered; a completing packet holds
//   the input until the walk has emitted its last beat.
// Reset clears all entry valid bits; no clearing pass is needed.
// While out_stall is high a held beat stays put and the walk waits.
`default_nettype none
module request_reassembly_table
    import rrt_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int MAX_PACKETS = 8,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [CLIENT_BITS-1:0]  src_client,
    input  wire logic [REQUEST_BITS-1:0] request_id,
    input  wire logic [SLOT_BITS-1:0]    slot_number,
    input  wire logic [TOTAL_BITS-1:0]   total_packets,
    input  wire logic [TYPE_BITS-1:0]    request_type,
    input  wire logic [15:0]             buffer_handle,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         status,
    output logic [CLIENT_BITS-1:0]       out_client,
    output logic [REQUEST_BITS-1:0]      out_request_id,
    output logic [TYPE_BITS-1:0]         out_type,
    output logic [SLOT_BITS-1:0]         out_slot,
    output logic [OUT_HANDLE_BITS-1:0]   out_handle,
    output logic                         last
);
    rrt_cmd_t cmd;
    rrt_sts_t sts;

    rrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rrt_datapath #(
        .ENTRIES     (ENTRIES),
        .MAX_PACKETS (MAX_PACKETS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .src_client     (src_client),
        .request_id     (request_id),
        .slot_number    (slot_number),
        .total_packets  (total_packets),
        .request_type   (request_type),
        .buffer_handle  (buffer_handle),
        .status         (status),
        .out_client     (out_client),
        .out_request_id (out_request_id),
        .out_type       (out_type),
        .out_slot       (out_slot),
        .out_handle     (out_handle),
        .last           (last)
    );
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for request_reassembly_table: directed and random packet traffic, scoreboard.
`timescale 1ns / 100ps
module tb_top;
    import rrt_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic        status;
        logic [15:0] client;
        logic [31:0] request;
        logic [15:0] rtype;
        logic [2:0]  slot;
        logic [15:0] handle;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] src_client = '0;
    logic [31:0] request_id = '0;
    logic [2:0]  slot_number = '0;
    logic [3:0]  total_packets = '0;
    logic [15:0] request_type = '0;
    logic [15:0] buffer_handle = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic [15:0] out_client;
    logic [31:0] out_request_id;
    logic [15:0] out_type;
    logic [2:0]  out_slot;
    logic [15:0] out_handle;
    logic        last;

    request_reassembly_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .src_client(src_client), .request_id(request_id), .slot_number(slot_number),
        .total_packets(total_packets), .request_type(request_type),
        .buffer_handle(buffer_handle),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .out_client(out_client), .out_request_id(out_request_id),
        .out_type(out_type), .out_slot(out_slot), .out_handle(out_handle), .last(last)
    );

    // Predicted table contents
    bit          tbl_valid [NUM_ENTRIES];
    logic [15:0] tbl_client [NUM_ENTRIES];
    logic [31:0] tbl_request [NUM_ENTRIES];
    logic [15:0] tbl_type [NUM_ENTRIES];
    int          tbl_total [NUM_ENTRIES];
    int          tbl_remaining [NUM_ENTRIES];
    logic [15:0] tbl_handles [NUM_ENTRIES][SLOTS];

    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic result_t make_result(logic st, logic [15:0] cl, logic [31:0] rq,
                                            logic [15:0] ty, logic [2:0] sl,
                                            logic [15:0] h, logic lst);
        result_t r;
        r.status = st; r.client = cl; r.request = rq; r.rtype = ty;
        r.slot = sl; r.handle = h; r.last = lst;
        return r;
    endfunction

    // Lookup/update of the table for one packet; queues the results it causes
    function automatic void predict_packet(logic [15:0] cl, logic [31:0] rq, logic [2:0] sl,
                                           logic [3:0] tot_in, logic [15:0] ty,
                                           logic [15:0] h);
        int hit;
        int fre;
        int tot;
        hit = -1;
        fre = -1;
        tot = (tot_in == 0) ? 1 : ((tot_in > SLOTS) ? SLOTS : int'(tot_in));
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (tbl_valid[e]) begin
                if (hit < 0 && tbl_client[e] == cl && tbl_request[e] == rq)
                    hit = e;
            end else if (fre < 0) begin
                fre = e;
            end
        end
        if (hit >= 0) begin
            if (sl < tbl_total[hit])
                tbl_handles[hit][sl] = h;
            if (tbl_remaining[hit] > 0)
                tbl_remaining[hit]--;
            if (tbl_remaining[hit] == 0) begin
                for (int s = 0; s < tbl_total[hit]; s++)
                    pending_results.push_back(make_result(STATUS_DONE, tbl_client[hit],
                        tbl_request[hit], tbl_type[hit], 3'(s), tbl_handles[hit][s],
                        s + 1 == tbl_total[hit]));
                tbl_valid[hit] = 0;
            end
        end else if (tot == 1) begin
            pending_results.push_back(make_result(STATUS_DONE, cl, rq, ty, 3'd0,
                                                  (sl == 0) ? h : 16'h0, 1'b1));
        end else if (fre < 0) begin
            pending_results.push_back(make_result(STATUS_DROP, cl, rq, ty, sl, h, 1'b1));
        end else begin
            tbl_valid[fre] = 1;
            tbl_client[fre] = cl;
            tbl_request[fre] = rq;
            tbl_type[fre] = ty;
            tbl_total[fre] = tot;
            tbl_remaining[fre] = tot - 1;
            for (int s = 0; s < SLOTS; s++)
                tbl_handles[fre][s] = '0;
            if (sl < tot)
                tbl_handles[fre][sl] = h;
        end
    endfunction

    // Offer one packet beat; returns at the edge where it was taken
    task automatic send_packet(logic [15:0] cl, logic [31:0] rq, logic [2:0] sl,
                               logic [3:0] tot, logic [15:0] ty, logic [15:0] h);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        src_client <= cl;
        request_id <= rq;
        slot_number <= sl;
        total_packets <= tot;
        request_type <= ty;
        buffer_handle <= h;
        do
            @(posedge clk);
        while (in_stall);
        predict_packet(cl, rq, sl, tot, ty, h);
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Receiver stall, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status %b exp %b", status, exp_r.status));
                if (out_client !== exp_r.client)
                    report_mismatch($sformatf("client %h exp %h", out_client,
                                              exp_r.client));
                if (out_request_id !== exp_r.request)
                    report_mismatch($sformatf("request %h exp %h", out_request_id,
                                              exp_r.request));
                if (out_type !== exp_r.rtype)
                    report_mismatch($sformatf("type %h exp %h", out_type, exp_r.rtype));
                if (out_slot !== exp_r.slot)
                    report_mismatch($sformatf("slot %0d exp %0d", out_slot, exp_r.slot));
                if (out_handle !== exp_r.handle)
                    report_mismatch($sformatf("handle %h exp %h", out_handle,
                                              exp_r.handle));
                if (last !== exp_r.last)
                    report_mismatch($sformatf("last %b exp %b", last, exp_r.last));
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Single-packet requests, total clamping, full request, odd slots, duplicates
    task automatic test_basic_cases();
        send_packet(16'h0000, 32'h0000_0000, 3'd0, 4'd0, 16'h0000, 16'hFFFF);
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 3'd5, 4'd1, 16'hFFFF, 16'h1234);
        // total above the slot count is clamped to eight
        for (int s = 7; s >= 0; s--)
            send_packet(16'hFFFF, 32'hFFFF_FFFF, 3'(s), (s == 7) ? 4'd15 : 4'd3,
                        16'hA5A5, 16'(16'hF000 + s));
        // out-of-range slot and a duplicate leave slots 1 and 2 unfilled
        send_packet(16'h0001, 32'h8000_0000, 3'd7, 4'd3, 16'h5A5A, 16'h0000);
        send_packet(16'h0001, 32'h8000_0000, 3'd0, 4'd3, 16'h0000, 16'h1111);
        send_packet(16'h0001, 32'h8000_0000, 3'd0, 4'd3, 16'h0000, 16'h2222);
    endtask

    // Fill every entry, then a drop and a single request on a full table, then complete each entry
    task automatic test_table_full();
        for (int e = 0; e < NUM_ENTRIES; e++)
            send_packet(16'(16'h0100 + e), 32'(e), 3'd0, 4'd2, 16'(e), 16'(16'h0A00 + e));
        send_packet(16'h7777, 32'h0BAD_BEEF, 3'd6, 4'd4, 16'hDEAD, 16'hBEEF);
        send_packet(16'h7778, 32'h0BAD_BEEF, 3'd0, 4'd1, 16'hCAFE, 16'h00FF);
        for (int e = 0; e < NUM_ENTRIES; e++)
            send_packet(16'(16'h0100 + e), 32'(e), 3'd1, 4'd9, 16'hFFFF, 16'(16'h0B00 + e));
    endtask

    // Interleaved well-formed requests with some noise
    task automatic test_random_traffic(int items);
        logic [15:0] act_cl [4];
        logic [31:0] act_rq [4];
        logic [15:0] act_ty [4];
        int          act_tot [4];
        int          act_sent [4];
        int          k;
        for (int i = 0; i < 4; i++)
            act_sent[i] = 0;
        for (int n = 0; n < items; n++) begin
            k = $urandom_range(3);
            if ($urandom_range(99) < 10) begin
                send_packet(16'($urandom_range(3)), $urandom(), 3'($urandom()),
                            4'($urandom()), 16'($urandom()), 16'($urandom()));
            end else begin
                if (act_sent[k] == 0) begin
                    act_cl[k] = 16'($urandom());
                    act_rq[k] = $urandom();
                    act_ty[k] = 16'($urandom());
                    act_tot[k] = $urandom_range(1, SLOTS);
                end
                send_packet(act_cl[k], act_rq[k],
                            ($urandom_range(99) < 20) ? 3'($urandom()) : 3'(act_sent[k]),
                            4'(act_tot[k]), act_ty[k], 16'($urandom()));
                act_sent[k]++;
                if (act_sent[k] >= act_tot[k])
                    act_sent[k] = 0;
            end
        end
    endtask

    // Long receiver hold-off while packets keep coming
    task automatic test_backpressure();
        hold_cycles <= 400;
        for (int r = 0; r < 6; r++)
            for (int s = 0; s < 4; s++)
                send_packet(16'h4242, 32'(32'h100 + r), 3'(s), 4'd4, 16'h0042,
                            16'($urandom()));
    endtask

    initial begin
        for (int e = 0; e < NUM_ENTRIES; e++)
            tbl_valid[e] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_cases();
        test_table_full();

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(35);
        send_idle_pct = 58; recv_stall_pct = 0;
        test_random_traffic(35);
        send_idle_pct = 0;  recv_stall_pct = 58;
        test_random_traffic(35);
        send_idle_pct = 20; recv_stall_pct = 20;
        test_random_traffic(34);

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_backpressure();

        in_valid <= 1'b0;
        recv_stall_pct = 20;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rrt_pkg.sv
rtl/core/rrt_ram.sv
rtl/core/rrt_datapath.sv
rtl/core/rrt_ctrl.sv
rtl/core/request_reassembly_table.sv
sim/tb_top.sv
